// ===== design/ftp_pkg.sv =====
// Shared widths, command codes and constants for the fan tach turn period block.
package ftp_pkg;

   localparam int STAMP_W = 16;

   typedef logic [STAMP_W-1:0] stamp_type;

   // Command codes carried in the cmd field of an input word.
   localparam logic CMD_CAPTURE = 1'b0;
   localparam logic CMD_REARM   = 1'b1;

   // Top of the free-running timer, used by the wrap rule.
   localparam stamp_type TIMER_MAX = 16'hFFFF;

   // Reset value of the glitch threshold register.
   localparam stamp_type GLITCH_RESET = 16'd500;

endpackage

// ===== design/ftp_if.sv =====
// Valid/ready channel interfaces for the capture requests and the period responses.
interface ftp_req_if;
   import ftp_pkg::*;

   logic      valid;
   logic      ready;
   logic      cmd;
   stamp_type capture_time;

   modport source (output valid, output cmd, output capture_time, input ready);
   modport sink   (input valid, input cmd, input capture_time, output ready);
endinterface

interface ftp_rsp_if;
   import ftp_pkg::*;

   logic      valid;
   logic      ready;
   logic      period_valid;
   stamp_type turn_period;
   logic      edge_accepted;

   modport source (output valid, output period_valid, output turn_period,
                   output edge_accepted, input ready);
   modport sink   (input valid, input period_valid, input turn_period,
                   input edge_accepted, output ready);
endinterface

// ===== design/fan_tach_turn_period_core.sv =====
// Fan tach turn period measurement core: interval check, turn counting and period output.
// A response word is registered at the edge that accepts its request.
// Throughput: one request word per cycle, limited only by the response register draining.
// The single output register is the only stage; all interval and period math sits in front of it.
// Reset (synchronous, active high): armed, no stamps counted, wrap mark clear,
// glitch threshold 500, response register empty.
module fan_tach_turn_period_core #(
   parameter int PULSES_PER_TURN = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   ftp_req_if.sink                req_ch,
   ftp_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  ftp_pkg::stamp_type     csr_wr_data
);
   import ftp_pkg::*;

   // The edge index counts stored stamps of the running measurement and must hold
   // PULSES_PER_TURN itself.
   localparam int IDX_W = $clog2(PULSES_PER_TURN + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PULSES_PER_TURN);

   // Configuration.
   stamp_type glitch_ff;

   // Measurement state. Only the first stamp and the last accepted stamp are ever
   // read back, so two registers replace the whole stamp store: a rejected stamp
   // would be overwritten anyway, and the turn period uses the completing stamp
   // directly.
   stamp_type        first_ff, first_in;
   stamp_type        prev_ff, prev_in;
   logic [IDX_W-1:0] edge_index_ff, edge_index_in;
   logic             wrap_ff, wrap_in;
   logic             armed_ff, armed_in;

   // Response register.
   logic      rsp_valid_ff, rsp_valid_in;
   logic      period_valid_ff, period_valid_in;
   stamp_type turn_period_ff, turn_period_in;
   logic      edge_accepted_ff, edge_accepted_in;

   logic      accept;
   logic      first_stamp;
   logic      prev_below;
   stamp_type interval;
   logic      interval_ok;
   logic      wrap_now;
   logic      turn_done;
   stamp_type period;

   // A new word is taken whenever the response register is empty or is being drained.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Interval to the last accepted stamp. Equal stamps count as a full wrap.
   assign first_stamp = (edge_index_ff == '0);
   assign prev_below  = (prev_ff < req_ch.capture_time);
   assign interval    = prev_below ? (req_ch.capture_time - prev_ff)
                                   : ((TIMER_MAX - prev_ff) + req_ch.capture_time);
   assign interval_ok = (interval > glitch_ff);

   // The wrap mark is sticky even across rejected intervals, and the period of the
   // completing word already sees the wrap of that word.
   assign wrap_now  = wrap_ff || !prev_below;
   assign turn_done = interval_ok && (edge_index_ff == LAST_IDX);
   assign period    = wrap_now ? ((TIMER_MAX - first_ff) + req_ch.capture_time)
                               : (req_ch.capture_time - first_ff);

   always_comb begin
      first_in         = first_ff;
      prev_in          = prev_ff;
      edge_index_in    = edge_index_ff;
      wrap_in          = wrap_ff;
      armed_in         = armed_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      period_valid_in  = period_valid_ff;
      turn_period_in   = turn_period_ff;
      edge_accepted_in = edge_accepted_ff;

      if (accept) begin
         rsp_valid_in     = 1'b1;
         period_valid_in  = 1'b0;
         turn_period_in   = '0;
         edge_accepted_in = 1'b0;

         if (req_ch.cmd == CMD_REARM) begin
            // Rearm leaves a running measurement untouched.
            armed_in = 1'b1;
         end else if (armed_ff) begin
            if (first_stamp) begin
               first_in         = req_ch.capture_time;
               prev_in          = req_ch.capture_time;
               edge_index_in    = IDX_W'(1);
               edge_accepted_in = 1'b1;
            end else begin
               wrap_in = wrap_now;
               if (interval_ok) begin
                  edge_accepted_in = 1'b1;
                  prev_in          = req_ch.capture_time;
                  if (turn_done) begin
                     period_valid_in = 1'b1;
                     turn_period_in  = period;
                     armed_in        = 1'b0;
                     wrap_in         = 1'b0;
                     edge_index_in   = '0;
                  end else begin
                     edge_index_in = edge_index_ff + IDX_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_ff     <= GLITCH_RESET;
         edge_index_ff <= '0;
         wrap_ff       <= 1'b0;
         armed_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            glitch_ff <= csr_wr_data;
         end
         edge_index_ff <= edge_index_in;
         wrap_ff       <= wrap_in;
         armed_ff      <= armed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff         <= first_in;
      prev_ff          <= prev_in;
      period_valid_ff  <= period_valid_in;
      turn_period_ff   <= turn_period_in;
      edge_accepted_ff <= edge_accepted_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.period_valid  = period_valid_ff;
   assign rsp_ch.turn_period   = turn_period_ff;
   assign rsp_ch.edge_accepted = edge_accepted_ff;

   // A completed turn disarms the block and restarts the stamp count.
   assert property (@(posedge clock) disable iff (reset)
      (accept && turn_done && armed_ff && !first_stamp && req_ch.cmd == CMD_CAPTURE)
      |=> (!armed_ff && edge_index_ff == '0 && !wrap_ff))
      else $error("completed turn did not disarm and clear the measurement");

   // The stamp count never goes past the turn length between words.
   assert property (@(posedge clock) disable iff (reset)
      edge_index_ff <= LAST_IDX)
      else $error("edge index out of range");

   // A capture while disarmed produces an all-zero response and keeps the block disarmed.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !armed_ff && req_ch.cmd == CMD_CAPTURE)
      |=> (rsp_valid_ff && !period_valid_ff && !edge_accepted_ff && !armed_ff))
      else $error("disarmed capture changed state or reported an edge");

   // A reported period always comes with an accepted edge; otherwise the period is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (period_valid_ff ? edge_accepted_ff : (turn_period_ff == '0)))
      else $error("inconsistent response fields");

endmodule

// ===== tb/tb_fan_tach_turn_period_core.sv =====
// Self-checking testbench for the fan tach turn period core under random valid/ready traffic.
`timescale 1ns / 100ps

module tb_fan_tach_turn_period_core;
   import ftp_pkg::*;

   // The core is built for four tach pulses per fan turn.
   localparam int TURN_PULSES  = 4;
   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT  = 5000;
   // Length of the one long response hold-off that fills the core.
   localparam int LONG_HOLD    = 300;
   // Random words after the directed opening, spread over the threshold phases.
   localparam int RANDOM_WORDS = 1930;
   localparam int PHASES       = 6;

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   stamp_type csr_wr_data;

   ftp_req_if req_ch ();
   ftp_rsp_if rsp_ch ();

   fan_tach_turn_period_core #(
      .PULSES_PER_TURN (TURN_PULSES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // One response word as the core should produce it.
   typedef struct packed {
      logic      period_valid;
      stamp_type turn_period;
      logic      edge_accepted;
   } period_word_type;

   // The ledger tracks the measurement the core should be doing. Every accepted
   // request word advances its own copy of the stamp slots, the edge count, the
   // sticky wrap mark and the armed flag, and queues the response word that the
   // request must produce. Response words are checked against the oldest entry.
   class turn_period_ledger;
      stamp_type       threshold;
      stamp_type       stamps [TURN_PULSES+1];
      int unsigned     turn_edges;
      bit              wrapped;
      bit              armed;
      period_word_type pending [$];
      int unsigned     mismatch_count;

      function new();
         threshold      = GLITCH_RESET;
         turn_edges     = 0;
         wrapped        = 1'b0;
         armed          = 1'b1;
         mismatch_count = 0;
      endfunction

      function void record_request(logic cmd, stamp_type stamp);
         period_word_type want;
         stamp_type       prev;
         int              interval;
         int              span;
         want = '0;
         if (cmd == CMD_REARM) begin
            // A rearm only sets the armed flag; a running measurement goes on.
            armed = 1'b1;
         end else if (armed) begin
            if (turn_edges == 0) begin
               // The first stamp of a turn is kept as is.
               stamps[0]          = stamp;
               turn_edges         = 1;
               want.edge_accepted = 1'b1;
            end else begin
               // The stamp lands in the current slot even if it is rejected,
               // so a glitch is overwritten by the next stamp.
               stamps[turn_edges] = stamp;
               prev               = stamps[turn_edges-1];
               if (prev < stamp) begin
                  interval = int'(stamp) - int'(prev);
               end else begin
                  // Equal stamps also take the wrap path.
                  interval = int'(TIMER_MAX) - int'(prev) + int'(stamp);
                  wrapped  = 1'b1;
               end
               if (interval > int'(threshold)) begin
                  want.edge_accepted = 1'b1;
                  if (turn_edges == TURN_PULSES) begin
                     if (wrapped)
                        span = int'(TIMER_MAX) - int'(stamps[0]) + int'(stamps[TURN_PULSES]);
                     else
                        span = int'(stamps[TURN_PULSES]) - int'(stamps[0]);
                     want.period_valid = 1'b1;
                     want.turn_period  = stamp_type'(span);
                     armed             = 1'b0;
                     wrapped           = 1'b0;
                     turn_edges        = 0;
                  end else begin
                     turn_edges++;
                  end
               end
            end
         end
         pending.push_back(want);
      endfunction

      task flag_mismatch(string what);
         $display("%0t ns: mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      task check_response(logic period_valid, stamp_type turn_period, logic edge_accepted);
         period_word_type want;
         if (pending.size() == 0) begin
            flag_mismatch($sformatf("response word with no request outstanding (%b %h %b)",
                                    period_valid, turn_period, edge_accepted));
            return;
         end
         want = pending.pop_front();
         if (period_valid !== want.period_valid)
            flag_mismatch($sformatf("period_valid got %b expected %b",
                                    period_valid, want.period_valid));
         if (turn_period !== want.turn_period)
            flag_mismatch($sformatf("turn_period got %h expected %h",
                                    turn_period, want.turn_period));
         if (edge_accepted !== want.edge_accepted)
            flag_mismatch($sformatf("edge_accepted got %b expected %b",
                                    edge_accepted, want.edge_accepted));
      endtask
   endclass

   turn_period_ledger ledger;

   // Sender and receiver coordination. The long hold request is only ever
   // written with nonblocking assignments at falling edges, so the receiver
   // sees it at the next falling edge regardless of process order.
   bit          long_hold_req;
   bit          sender_calm;
   int unsigned words_sent;
   stamp_type   tick;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle stretches for both sides: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Timer advance between two tach edges. Most steps clear the current glitch
   // threshold, some sit right on it, some are glitches and some repeat the
   // previous stamp. Wide steps carry the timer across its wrap point.
   function automatic int unsigned pick_step();
      int unsigned thr;
      int unsigned roll;
      thr  = ledger.threshold;
      roll = $urandom_range(0, 99);
      if (thr == TIMER_MAX || roll < 12) return $urandom_range(0, thr);
      if (roll < 16) return 0;
      if (roll < 22) return thr + $urandom_range(0, 2);
      if (roll < 70) return $urandom_range(thr + 1, (thr + 2000 > 65535) ? 65535 : thr + 2000);
      return $urandom_range(thr + 1, 65535);
   endfunction

   // Offers one request word from a falling edge, waits for the handshake and
   // leaves the channel at a falling edge, either still valid for the next
   // word or idle for a random gap.
   task automatic send_word(input logic cmd, input stamp_type stamp);
      int unsigned gap;
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.capture_time <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ledger.record_request(cmd, stamp);
      words_sent++;
      @(negedge clock);
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops offering and waits until every expected response word is back,
   // then lets the single output stage settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input stamp_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      ledger.threshold = value;
   endtask

   // One measurement: a first stamp, then stamps until the ledger says the
   // turn is complete (or a cap is hit), then usually a rearm. Broken turns
   // stop early, slip in a rearm mid-turn, or skip the final rearm.
   task automatic run_turn(input bit broken);
      int unsigned tries;
      int unsigned cap;
      tries = 0;
      cap   = broken ? $urandom_range(1, 4) : 16;
      send_word(CMD_CAPTURE, tick);
      while (ledger.armed && tries < cap) begin
         if (broken && $urandom_range(0, 3) == 0)
            send_word(CMD_REARM, stamp_type'($urandom));
         tick = tick + stamp_type'(pick_step());
         send_word(CMD_CAPTURE, tick);
         tries++;
      end
      if (!broken || $urandom_range(0, 1) == 0)
         send_word(CMD_REARM, stamp_type'($urandom));
   endtask

   // Unstructured words: random commands and stamps.
   task automatic run_noise();
      int unsigned count;
      count = $urandom_range(1, 6);
      repeat (count)
         send_word(($urandom_range(0, 3) == 0) ? CMD_REARM : CMD_CAPTURE,
                   stamp_type'($urandom));
   endtask

   // Response side: ready changes at falling edges. Calm stretches keep ready
   // high; otherwise random stalls are drawn. One long hold is served on
   // request while the sender keeps pushing, which backs up the core.
   initial begin : rsp_ready_drive
      int unsigned hold;
      bit          calm;
      rsp_ch.ready = 1'b0;
      hold         = 0;
      calm         = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) calm = ($urandom_range(0, 3) == 0);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else if (long_hold_req) begin
            long_hold_req <= 1'b0;
            rsp_ch.ready  <= 1'b0;
            hold = LONG_HOLD - 1;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            hold = pick_gap();
            rsp_ch.ready <= (hold == 0);
            if (hold > 0) hold--;
         end
      end
   end

   // Every accepted response word is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         ledger.check_response(rsp_ch.period_valid, rsp_ch.turn_period, rsp_ch.edge_accepted);
   end

   // Watchdog: a run that stops moving words on both channels is hung.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned budget;
      int unsigned start;
      int unsigned roll;
      bit          pause_done;
      stamp_type   thr;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_CAPTURE;
      req_ch.capture_time = '0;
      long_hold_req       = 1'b0;
      sender_calm         = 1'b0;
      words_sent          = 0;
      pause_done          = 1'b0;
      tick                = stamp_type'($urandom);
      ledger              = new();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening, run at the reset threshold of 500 ticks.
      // A turn with a glitch right at the threshold, a rearm while armed,
      // an equal stamp pair (counts as a wrap) and a period that overflows
      // sixteen bits.
      send_word(CMD_CAPTURE, 16'd0);
      send_word(CMD_CAPTURE, 16'd500);
      send_word(CMD_CAPTURE, 16'd501);
      send_word(CMD_REARM,   16'd0);
      send_word(CMD_CAPTURE, 16'd501);
      send_word(CMD_CAPTURE, 16'hFFFF);
      send_word(CMD_CAPTURE, 16'hFFFF);
      // The turn is complete, so this capture is ignored until the rearm.
      send_word(CMD_CAPTURE, 16'd1234);
      send_word(CMD_REARM,   16'hFFFF);
      // A timer wrap that is rejected as a glitch still leaves the wrap mark set.
      send_word(CMD_CAPTURE, 16'hFFFF);
      send_word(CMD_CAPTURE, 16'd0);
      send_word(CMD_CAPTURE, 16'd1000);
      send_word(CMD_CAPTURE, 16'd2000);
      send_word(CMD_CAPTURE, 16'd3000);
      send_word(CMD_CAPTURE, 16'd4000);
      send_word(CMD_REARM,   16'd0);
      // A plain turn with no wrap at all.
      send_word(CMD_CAPTURE, 16'd100);
      send_word(CMD_CAPTURE, 16'd700);
      send_word(CMD_CAPTURE, 16'd1300);
      send_word(CMD_CAPTURE, 16'd1900);
      send_word(CMD_CAPTURE, 16'd2500);
      send_word(CMD_REARM,   16'd0);

      // Random phases, each at its own glitch threshold. The threshold is only
      // changed once the core has returned every response word.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       thr = '0;
            1:       thr = TIMER_MAX;
            2:       thr = stamp_type'($urandom_range(2, 19999));
            3:       thr = 16'd1;
            4:       thr = GLITCH_RESET;
            default: thr = stamp_type'($urandom_range(20000, 60000));
         endcase
         // At the top threshold every interval is a glitch, so that phase is short.
         budget = (thr == TIMER_MAX) ? 60 : (RANDOM_WORDS - 60) / (PHASES - 1);
         drain();
         csr_write(thr);
         start = words_sent;
         while (words_sent - start < budget) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            if (phase == 2 && words_sent - start == 0) begin
               // Hold the response side for a long stretch while words keep coming.
               long_hold_req <= 1'b1;
               sender_calm = 1'b1;
            end
            if (phase == 3 && !pause_done && words_sent - start > budget / 2) begin
               // Let the core run completely dry in the middle of a phase.
               drain();
               pause_done = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 80)
               run_turn(1'b0);
            else if (roll < 90)
               run_turn(1'b1);
            else
               run_noise();
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (ledger.mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/ftp_pkg.sv
design/ftp_if.sv
design/fan_tach_turn_period_core.sv
tb/tb_fan_tach_turn_period_core.sv
